@@ rtl/swmt_pkg.sv @@
// Shared types and constants of the sliding window median time block.
// No dependencies; every other file of the block uses this package.
package swmt_pkg;

    localparam int WINDOW_SIZE = 11;
    localparam int TS_W        = 64;
    localparam int COUNT_W     = 4;
    localparam int SLOT_W      = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int FILL_W      = $clog2(WINDOW_SIZE + 1);

    localparam logic signed [TS_W-1:0] TS_MIN = {1'b1, {(TS_W-1){1'b0}}};

    localparam logic REQ_PUSH  = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DELIVER
    } t_state;

    typedef struct packed {
        logic              push;
        logic              clear;
        logic              issue;
        logic [SLOT_W-1:0] idx;
        logic              flush;
        logic              load_out;
    } t_cmd;

    typedef struct packed {
        logic              found;
        logic [FILL_W-1:0] fill;
    } t_stat;

endpackage

@@ rtl/swmt_in_if.sv @@
// Input channel of the median block: valid, ready and one request item.
// Depends on swmt_pkg for the timestamp width.
interface swmt_in_if;
    logic                              valid;
    logic                              ready;
    logic                              req_type;
    logic signed [swmt_pkg::TS_W-1:0]  timestamp;

    modport source (output valid, output req_type, output timestamp, input ready);
    modport sink   (input valid, input req_type, input timestamp, output ready);
endinterface

@@ rtl/swmt_out_if.sv @@
// Result channel of the median block: valid, ready, median and window count.
// Depends on swmt_pkg for the field widths.
interface swmt_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [swmt_pkg::TS_W-1:0]    median;
    logic        [swmt_pkg::COUNT_W-1:0] window_count;

    modport source (output valid, output median, output window_count, input ready);
    modport sink   (input valid, input median, input window_count, output ready);
endinterface

@@ rtl/swmt_ctrl.sv @@
// Controller of the median block: request decode, rank scan sequencing and
// output handshake. Depends on swmt_pkg for the state, command and status types.
module swmt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_req_type,
    input  logic           i_out_ready,
    input  swmt_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output swmt_pkg::t_cmd  o_cmd
);

    swmt_pkg::t_state            r_state, n_state;
    logic [swmt_pkg::SLOT_W-1:0] r_idx, n_idx;
    logic                        r_out_valid;
    logic                        w_last;
    logic                        w_out_free;

    assign w_last     = (swmt_pkg::FILL_W'(r_idx) == i_stat.fill - swmt_pkg::FILL_W'(1));
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            swmt_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_idx = '0;
                    if (i_req_type == swmt_pkg::REQ_CLEAR) begin
                        n_state = swmt_pkg::ST_DELIVER;
                    end else begin
                        n_state = swmt_pkg::ST_SCAN;
                    end
                end
            end
            swmt_pkg::ST_SCAN: begin
                if (i_stat.found) begin
                    n_state = swmt_pkg::ST_DELIVER;
                end else if (w_last) begin
                    n_state = swmt_pkg::ST_DRAIN;
                end else begin
                    n_idx = r_idx + swmt_pkg::SLOT_W'(1);
                end
            end
            swmt_pkg::ST_DRAIN: begin
                if (i_stat.found) begin
                    n_state = swmt_pkg::ST_DELIVER;
                end
            end
            swmt_pkg::ST_DELIVER: begin
                if (w_out_free) begin
                    n_state = swmt_pkg::ST_IDLE;
                end
            end
            default: n_state = swmt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_cmd.idx  = r_idx;
        case (r_state)
            swmt_pkg::ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.push  = i_in_valid && (i_req_type == swmt_pkg::REQ_PUSH);
                o_cmd.clear = i_in_valid && (i_req_type == swmt_pkg::REQ_CLEAR);
            end
            swmt_pkg::ST_SCAN: begin
                o_cmd.issue = 1'b1;
            end
            swmt_pkg::ST_DRAIN: begin
                o_cmd.issue = 1'b0;
            end
            swmt_pkg::ST_DELIVER: begin
                o_cmd.flush    = 1'b1;
                o_cmd.load_out = w_out_free;
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swmt_pkg::ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/swmt_dpath.sv @@
// Datapath of the median block: timestamp ring, three-stage rank pipeline
// and output register. Depends on swmt_pkg for widths and the command types.
module swmt_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  swmt_pkg::t_cmd                      i_cmd,
    input  logic signed [swmt_pkg::TS_W-1:0]    i_timestamp,
    output swmt_pkg::t_stat                     o_stat,
    output logic signed [swmt_pkg::TS_W-1:0]    o_median,
    output logic        [swmt_pkg::COUNT_W-1:0] o_window_count
);

    logic signed [swmt_pkg::TS_W-1:0]    r_store [swmt_pkg::WINDOW_SIZE];
    logic [swmt_pkg::SLOT_W-1:0]         r_slot;
    logic [swmt_pkg::FILL_W-1:0]         r_fill;

    logic                                r_v_a;
    logic signed [swmt_pkg::TS_W-1:0]    r_cand_a;
    logic [swmt_pkg::SLOT_W-1:0]         r_idx_a;

    logic [swmt_pkg::WINDOW_SIZE-1:0]    w_lt;
    logic                                r_v_b;
    logic signed [swmt_pkg::TS_W-1:0]    r_cand_b;
    logic [swmt_pkg::WINDOW_SIZE-1:0]    r_lt_b;

    logic                                w_found;
    logic signed [swmt_pkg::TS_W-1:0]    r_med;
    logic signed [swmt_pkg::TS_W-1:0]    r_out_median;
    logic [swmt_pkg::COUNT_W-1:0]        r_out_count;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_store[r_slot] <= i_timestamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_fill <= '0;
        end else if (i_cmd.clear) begin
            r_slot <= '0;
            r_fill <= '0;
        end else if (i_cmd.push) begin
            if (r_slot == swmt_pkg::SLOT_W'(swmt_pkg::WINDOW_SIZE - 1)) begin
                r_slot <= '0;
            end else begin
                r_slot <= r_slot + swmt_pkg::SLOT_W'(1);
            end
            if (r_fill != swmt_pkg::FILL_W'(swmt_pkg::WINDOW_SIZE)) begin
                r_fill <= r_fill + swmt_pkg::FILL_W'(1);
            end
        end
    end

    // Stage A: fetch the candidate entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a <= 1'b0;
        end else begin
            r_v_a <= i_cmd.issue && !i_cmd.flush;
        end
        r_cand_a <= r_store[i_cmd.idx];
        r_idx_a  <= i_cmd.idx;
    end

    // Stage B: compare the candidate against every live entry at once.
    // Equal values rank by slot, so each candidate gets a distinct rank.
    always_comb begin
        for (int j = 0; j < swmt_pkg::WINDOW_SIZE; j++) begin
            w_lt[j] = (swmt_pkg::FILL_W'(j) < r_fill) &&
                      ((r_store[j] < r_cand_a) ||
                       ((r_store[j] == r_cand_a) && (swmt_pkg::SLOT_W'(j) < r_idx_a)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_b <= 1'b0;
        end else begin
            r_v_b <= r_v_a && !i_cmd.flush;
        end
        r_cand_b <= r_cand_a;
        r_lt_b   <= w_lt;
    end

    // Stage C: the candidate whose rank equals fill/2 is the median.
    assign w_found = r_v_b &&
                     (swmt_pkg::FILL_W'($countones(r_lt_b)) == (r_fill >> 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_med <= swmt_pkg::TS_MIN;
        end else if (w_found) begin
            r_med <= r_cand_b;
        end
        if (i_cmd.load_out) begin
            r_out_median <= r_med;
            r_out_count  <= swmt_pkg::COUNT_W'(r_fill);
        end
    end

    assign o_stat.found   = w_found;
    assign o_stat.fill    = r_fill;
    assign o_median       = r_out_median;
    assign o_window_count = r_out_count;

endmodule

@@ rtl/sliding_window_median_time.sv @@
// Top level of the sliding window median time block (median time past).
// Depends on swmt_pkg, swmt_in_if, swmt_out_if, swmt_ctrl and swmt_dpath.
//
//  Channel   Role     Payload                         Accepted when
//  i_in      sink     req_type, timestamp             i_in.valid && i_in.ready
//  o_out     source   median, window_count            o_out.valid && o_out.ready
//
// A push runs the rank scan, which issues one candidate entry per cycle into a
// three-stage compare pipeline; the result loads once the median is found and the
// output register is free, and the next item is taken in the cycle after that load.
// A clear goes straight to delivery and loads its result once the output register is
// free. Reset is synchronous and active low; it empties the window. The input is taken
// only in the idle state; a waiting result does not stop the next item being accepted.
module sliding_window_median_time (
    input  logic        i_clk,
    input  logic        i_rst_n,
    swmt_in_if.sink     i_in,
    swmt_out_if.source  o_out
);

    swmt_pkg::t_cmd  w_cmd;
    swmt_pkg::t_stat w_stat;
    logic            w_in_ready;
    logic            w_out_valid;

    // The controller decodes each request, steps the candidate index through
    // the filled slots and owns the output valid flag.
    swmt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_req_type  (i_in.req_type),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    // The datapath keeps the ring of timestamps, ranks candidates and holds
    // the result payload.
    swmt_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_timestamp    (i_in.timestamp),
        .o_stat         (w_stat),
        .o_median       (o_out.median),
        .o_window_count (o_out.window_count)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

    // While idle the rank pipeline is flushed, so no median may be found.
    a_no_found_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_ready |-> !w_stat.found)
        else $error("median found while idle");

    // A clear empties the window.
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && w_in_ready && (i_in.req_type == swmt_pkg::REQ_CLEAR))
        |=> (w_stat.fill == '0))
        else $error("window not empty after clear");

    // A push into a window that is not full grows it by one.
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && w_in_ready && (i_in.req_type == swmt_pkg::REQ_PUSH) &&
         (w_stat.fill != swmt_pkg::FILL_W'(swmt_pkg::WINDOW_SIZE)))
        |=> (w_stat.fill == $past(w_stat.fill) + swmt_pkg::FILL_W'(1)))
        else $error("window count did not advance on push");

    // The output register is never overwritten while its item waits.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!w_out_valid || o_out.ready))
        else $error("pending result overwritten");

endmodule

@@ bench/swmt_checker.sv @@
// Passive checker for the sliding window median time block: it watches both channels,
// predicts every result from the accepted request items and compares field by field.
// Depends on swmt_pkg, swmt_in_if and swmt_out_if.
module swmt_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    swmt_in_if   i_in,
    swmt_out_if  i_out,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [swmt_pkg::TS_W-1:0]    median;
        logic        [swmt_pkg::COUNT_W-1:0] count;
    } t_median;

    t_median                          medians_due[$];
    logic signed [swmt_pkg::TS_W-1:0] stamps [swmt_pkg::WINDOW_SIZE];
    int unsigned                      write_slot = 0;
    int unsigned                      held       = 0;
    int                               fail_total = 0;

    // Value of rank k among the first n slots; equal values rank by slot index.
    function automatic logic signed [swmt_pkg::TS_W-1:0] rank_pick(int unsigned n,
                                                                   int unsigned k);
        int unsigned rank;
        for (int unsigned i = 0; i < n; i++) begin
            rank = 0;
            for (int unsigned j = 0; j < n; j++) begin
                if (stamps[j] < stamps[i] || (stamps[j] == stamps[i] && j < i))
                    rank++;
            end
            if (rank == k)
                return stamps[i];
        end
        return swmt_pkg::TS_MIN;
    endfunction

    // Applies one request to the shadow window and returns the median it reports.
    function automatic t_median window_update(logic req,
                                              logic signed [swmt_pkg::TS_W-1:0] ts);
        t_median res;
        if (req == swmt_pkg::REQ_CLEAR) begin
            held       = 0;
            write_slot = 0;
            res.median = swmt_pkg::TS_MIN;
            res.count  = '0;
        end else begin
            stamps[write_slot] = ts;
            write_slot = (write_slot + 1 == swmt_pkg::WINDOW_SIZE) ? 0 : write_slot + 1;
            if (held < swmt_pkg::WINDOW_SIZE)
                held++;
            res.median = rank_pick(held, held / 2);
            res.count  = swmt_pkg::COUNT_W'(held);
        end
        return res;
    endfunction

    task automatic flag(string field, logic signed [swmt_pkg::TS_W-1:0] want,
                        logic signed [swmt_pkg::TS_W-1:0] got);
        fail_total++;
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
    endtask

    always @(posedge i_clk) begin
        t_median want;
        if (!i_rst_n) begin
            medians_due.delete();
            held       = 0;
            write_slot = 0;
        end else begin
            // Results leave before the item accepted at this edge can produce one.
            if (i_out.valid && i_out.ready) begin
                if (medians_due.size() == 0) begin
                    fail_total++;
                    $error("unexpected result: median %0d, window_count %0d",
                           i_out.median, i_out.window_count);
                end else begin
                    want = medians_due.pop_front();
                    if (want.median !== i_out.median)
                        flag("median", want.median, i_out.median);
                    if (want.count !== i_out.window_count)
                        flag("window_count", want.count, i_out.window_count);
                end
            end
            if (i_in.valid && i_in.ready)
                medians_due.push_back(window_update(i_in.req_type, i_in.timestamp));
        end
        o_pending    <= medians_due.size();
        o_fail_count <= fail_total;
    end

endmodule

@@ bench/tb_sliding_window_median_time.sv @@
// Top of the median time past testbench: clock, reset, request stimulus, result
// back-pressure, watchdog and verdict. Depends on swmt_pkg, both channel interfaces,
// the block itself and swmt_checker, which does all prediction and comparison.
module tb_sliding_window_median_time;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 1600;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AT        = 500;
    localparam int QUIET_FROM     = 800;
    localparam int QUIET_TO       = 1100;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 3000;

    localparam logic signed [swmt_pkg::TS_W-1:0] TS_MAX = ~swmt_pkg::TS_MIN;

    logic i_clk;
    logic i_rst_n;

    swmt_in_if  in_ch ();
    swmt_out_if out_ch ();

    int fail_count;
    int pending;
    int results_taken = 0;

    // The sender leaves gaps between items unless this is cleared.
    bit sender_gaps_on = 1'b1;

    // Slowly advancing chain time around which most random timestamps fall.
    logic signed [swmt_pkg::TS_W-1:0] stamp_base;

    sliding_window_median_time u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    swmt_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Results taken so far; the receiver uses it to place its hold-off and its
    // stretch without stalls. It is read only at falling edges.
    always @(posedge i_clk) begin
        if (out_ch.valid && out_ch.ready)
            results_taken <= results_taken + 1;
    end

    // Picks a timestamp. Most follow a drifting chain time with jitter wide enough
    // to come out of order; small values give many ties, and a share covers the
    // extremes and fully random bit patterns so that every bit toggles.
    function automatic logic signed [swmt_pkg::TS_W-1:0] pick_stamp();
        logic signed [swmt_pkg::TS_W-1:0] ts;
        case ($urandom_range(0, 9))
            0: ts = {$urandom(), $urandom()};
            1: begin
                case ($urandom_range(0, 3))
                    0:       ts = swmt_pkg::TS_MIN;
                    1:       ts = TS_MAX;
                    2:       ts = '0;
                    default: ts = -64'sd1;
                endcase
            end
            2, 3: ts = $signed({32'd0, $urandom_range(0, 16)}) - 64'sd8;
            default: begin
                stamp_base = stamp_base + $signed({32'd0, $urandom_range(0, 1200)});
                ts = stamp_base + $signed({32'd0, $urandom_range(0, 2400)}) - 64'sd1200;
            end
        endcase
        return ts;
    endfunction

    // Offers one request item and returns at the falling edge after it was taken.
    // Valid stays high into the next item unless a gap is drawn.
    task automatic offer(input logic req, input logic signed [swmt_pkg::TS_W-1:0] ts);
        if (sender_gaps_on && $urandom_range(0, 99) < 20) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.req_type  = req;
        in_ch.timestamp = ts;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    // Receiver. Ready changes only at falling edges. Once, after a few hundred
    // results, it holds off long enough for the block to fill its output register,
    // finish the next item and stall the sender. Later it runs a stretch with no
    // stalls at all; otherwise it drops ready at random, with a chance of nine in a hundred.
    initial begin
        bit held_once;
        held_once    = 1'b0;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!held_once && results_taken >= HOLD_AT) begin
                held_once    = 1'b1;
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (results_taken >= QUIET_FROM && results_taken < QUIET_TO) begin
                out_ch.ready = 1'b1;
            end else begin
                out_ch.ready = ($urandom_range(0, 99) >= 9);
            end
        end
    end

    // Watchdog: ends the run when neither channel moves an item for too long.
    // The longest legal pause is the receiver's hold-off.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        in_ch.valid     = 1'b0;
        in_ch.req_type  = swmt_pkg::REQ_PUSH;
        in_ch.timestamp = '0;
        i_rst_n         = 1'b0;
        stamp_base      = 64'sd1600000000;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. A clear on an empty window, then the extremes and ties
        // while the window fills, eleven entries to reach a full window, pushes
        // that overwrite the oldest entries, a clear carrying a nonzero timestamp,
        // equal extremes after it and a final clear followed by one push.
        offer(swmt_pkg::REQ_CLEAR, '0);
        offer(swmt_pkg::REQ_PUSH, swmt_pkg::TS_MIN);
        offer(swmt_pkg::REQ_PUSH, TS_MAX);
        offer(swmt_pkg::REQ_PUSH, '0);
        offer(swmt_pkg::REQ_PUSH, -64'sd1);
        offer(swmt_pkg::REQ_PUSH, 64'sd1);
        offer(swmt_pkg::REQ_PUSH, '0);
        offer(swmt_pkg::REQ_PUSH, '0);
        offer(swmt_pkg::REQ_PUSH, TS_MAX);
        offer(swmt_pkg::REQ_PUSH, swmt_pkg::TS_MIN);
        offer(swmt_pkg::REQ_PUSH, -64'sd1);
        offer(swmt_pkg::REQ_PUSH, 64'sd5);
        offer(swmt_pkg::REQ_PUSH, 64'sd7);
        offer(swmt_pkg::REQ_PUSH, 64'sd7);
        offer(swmt_pkg::REQ_PUSH, swmt_pkg::TS_MIN);
        offer(swmt_pkg::REQ_CLEAR, TS_MAX);
        offer(swmt_pkg::REQ_PUSH, TS_MAX);
        offer(swmt_pkg::REQ_PUSH, TS_MAX);
        offer(swmt_pkg::REQ_PUSH, swmt_pkg::TS_MIN);
        offer(swmt_pkg::REQ_CLEAR, -64'sd1);
        offer(swmt_pkg::REQ_PUSH, 64'sd3);

        // Random part: mostly pushes, with a clear now and then so that every fill
        // level from empty to full and the wrap of the oldest slot keep recurring.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sender_gaps_on = !(n >= QUIET_FROM && n < QUIET_TO);
            if ($urandom_range(0, 99) < 4)
                offer(swmt_pkg::REQ_CLEAR, pick_stamp());
            else
                offer(swmt_pkg::REQ_PUSH, pick_stamp());
        end
        in_ch.valid = 1'b0;

        // Wait for every outstanding result, then a little longer so that a stray
        // extra result would still be seen.
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
